/* rtl/core/sqllex_pkg.sv */
// shared types and constants for the sql style lexer
// used by sqllex_decode and sql_style_lexer; no dependencies
package sqllex_pkg;

   localparam int MAX_RECS   = 4;
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int NREC_W     = $clog2(MAX_RECS + 1);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_WORD = 3'd1,
      MODE_OP   = 3'd2,
      MODE_INT  = 3'd3,
      MODE_STR  = 3'd4
   } mode_type;

   localparam logic [1:0] K_CHAR  = 2'd0;
   localparam logic [1:0] K_END   = 2'd1;
   localparam logic [1:0] K_DISC  = 2'd2;
   localparam logic [1:0] K_BADOP = 2'd3;

   localparam logic [2:0] C_WORD = 3'd0;
   localparam logic [2:0] C_OP   = 3'd1;
   localparam logic [2:0] C_INT  = 3'd2;
   localparam logic [2:0] C_STR  = 3'd3;
   localparam logic [2:0] C_SEP  = 3'd4;

   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CASE_OFS  = 8'd32;

   typedef struct packed {
      mode_type   mode;
      logic       in_comment;
      logic       quote_dq;
      logic [7:0] pend;
   } lex_state_type;

   localparam lex_state_type LEX_RESET = '{mode: MODE_IDLE, in_comment: 1'b0,
                                           quote_dq: 1'b0, pend: 8'd0};

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] token_class;
      logic [7:0] char_out;
      logic       last;
   } rec_type;

   typedef rec_type [MAX_RECS-1:0] rec_vec_type;

   function automatic rec_type mk_rec(logic [1:0] kind, logic [2:0] cls, logic [7:0] c);
      rec_type r;
      r.kind        = kind;
      r.token_class = cls;
      r.char_out    = c;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

/* rtl/core/sql_style_lexer.sv */
// sql style lexer top level: lexer state, decode step and result buffer
// depends on sqllex_pkg and sqllex_decode
// result words are registered in the result buffer before they reach the output port
// throughput: one result word per cycle while rsp_ready is high; an item is taken each cycle while the
// eight-entry result buffer has room for four more words, so items with one
// result run back to back and the output port sets the rate otherwise
// reset: synchronous, clears the lexer state and empties the result buffer
module sql_style_lexer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_token_class,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last
);
   import sqllex_pkg::*;

   lex_state_type     state_ff;
   lex_state_type     state_in;
   rec_vec_type       recs;
   logic [NREC_W-1:0] rec_cnt;
   logic              accept;
   logic              pop;
   logic [NREC_W-1:0] push_n;

   rec_type           buf_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wptr_ff;
   logic [PTR_W-1:0]  wptr_in;
   logic [PTR_W-1:0]  rptr_ff;
   logic [PTR_W-1:0]  rptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   sqllex_decode u_decode (
      .cur      (state_ff),
      .ch       (req_ch),
      .line_end (req_line_end),
      .nxt      (state_in),
      .recs     (recs),
      .rec_cnt  (rec_cnt)
   );

   assign req_ready = (count_ff <= CNT_W'(FIFO_DEPTH - MAX_RECS));
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign push_n    = accept ? rec_cnt : '0;

   assign wptr_in  = wptr_ff + PTR_W'(push_n);
   assign rptr_in  = rptr_ff + PTR_W'(pop);
   assign count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   assign rsp_valid       = (count_ff != '0);
   assign rsp_kind        = buf_ff[rptr_ff].kind;
   assign rsp_token_class = buf_ff[rptr_ff].token_class;
   assign rsp_char_out    = buf_ff[rptr_ff].char_out;
   assign rsp_last        = buf_ff[rptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LEX_RESET;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // result words land at consecutive slots starting at the write pointer
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RECS; i++) begin
         if (NREC_W'(i) < push_n) begin
            buf_ff[wptr_ff + PTR_W'(i)] <= recs[i];
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result buffer count out of range");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         count_ff == $past(count_ff) + CNT_W'($past(push_n)) - CNT_W'($past(pop)))
      else $error("result buffer count does not follow push and pop");

   a_comment_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && state_ff.in_comment && !req_line_end |-> push_n == '0)
      else $error("word pushed while inside a comment");

   a_pend_only_op: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode != MODE_OP |-> state_ff.pend == 8'd0)
      else $error("pending operator held outside operator mode");

endmodule

/* rtl/core/sqllex_decode.sv */
// one-character lexer step: state and character in, up to four records out
// depends on sqllex_pkg
module sqllex_decode (
   input  sqllex_pkg::lex_state_type cur,
   input  logic [7:0]                ch,
   input  logic                      line_end,
   output sqllex_pkg::lex_state_type nxt,
   output sqllex_pkg::rec_vec_type   recs,
   output logic [sqllex_pkg::NREC_W-1:0] rec_cnt
);
   import sqllex_pkg::*;

   rec_type           close0;
   rec_type           close1;
   logic [NREC_W-1:0] close_n;
   logic              is_space;
   logic              is_sep;
   logic              is_opch;
   logic              pair_ok;

   assign is_space = ch inside {CH_SP, CH_LF, CH_CR};
   assign is_sep   = ch inside {CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE,
                                CH_DOT, CH_COMMA, CH_SEMI};
   assign is_opch  = ch inside {CH_EQ, CH_BANG, CH_PLUS, CH_MINUS,
                                CH_STAR, CH_SLASH, CH_LT, CH_GT};
   assign pair_ok  = (cur.pend == CH_EQ    && ch == CH_EQ) ||
                     (cur.pend == CH_BANG  && ch == CH_EQ) ||
                     (cur.pend == CH_SLASH && ch == CH_SLASH) ||
                     (cur.pend == CH_LT    && ch == CH_EQ) ||
                     (cur.pend == CH_GT    && ch == CH_EQ) ||
                     (cur.pend == CH_LT    && ch == CH_GT);

   // records that closing the open token would give; always first in the list
   always_comb begin
      close0  = '0;
      close1  = '0;
      close_n = '0;
      case (cur.mode)
         MODE_WORD: begin
            close0  = mk_rec(K_END, C_WORD, 8'd0);
            close_n = NREC_W'(1);
         end
         MODE_OP: begin
            close0  = mk_rec(K_CHAR, C_OP, cur.pend);
            close1  = mk_rec(K_END, C_OP, 8'd0);
            close_n = NREC_W'(2);
         end
         MODE_INT: begin
            close0  = mk_rec(K_END, C_INT, 8'd0);
            close_n = NREC_W'(1);
         end
         default: begin
            close_n = '0;
         end
      endcase
   end

   always_comb begin
      logic [NREC_W-1:0] n;
      logic              quote_hit;
      nxt       = cur;
      recs      = '0;
      n         = '0;
      quote_hit = cur.quote_dq ? (ch == CH_DQUOTE) : (ch == CH_SQUOTE);
      if (line_end) begin
         if (cur.mode == MODE_STR) begin
            recs[0] = mk_rec(K_DISC, C_STR, 8'd0);
            n       = NREC_W'(1);
         end else begin
            recs[0] = close0;
            recs[1] = close1;
            n       = close_n;
         end
         nxt = LEX_RESET;
      end else if (cur.in_comment) begin
         if (ch == CH_LF || ch == CH_CR) begin
            nxt.in_comment = 1'b0;
         end
      end else if (cur.mode == MODE_STR) begin
         if (quote_hit) begin
            recs[0]      = mk_rec(K_END, C_STR, 8'd0);
            nxt.mode     = MODE_IDLE;
            nxt.quote_dq = 1'b0;
         end else begin
            recs[0] = mk_rec(K_CHAR, C_STR, ch);
         end
         n = NREC_W'(1);
      end else if (is_space) begin
         recs[0]  = close0;
         recs[1]  = close1;
         n        = close_n;
         nxt.mode = MODE_IDLE;
         nxt.pend = 8'd0;
      end else if (is_sep) begin
         recs[0]       = close0;
         recs[1]       = close1;
         recs[close_n[1:0]]          = mk_rec(K_CHAR, C_SEP, ch);
         recs[close_n[1:0] + 2'd1]   = mk_rec(K_END, C_SEP, 8'd0);
         n             = close_n + NREC_W'(2);
         nxt.mode      = MODE_IDLE;
         nxt.pend      = 8'd0;
      end else if (is_opch) begin
         if (cur.mode == MODE_OP) begin
            if (pair_ok) begin
               recs[0] = mk_rec(K_CHAR, C_OP, cur.pend);
               recs[1] = mk_rec(K_CHAR, C_OP, ch);
               recs[2] = mk_rec(K_END, C_OP, 8'd0);
               n       = NREC_W'(3);
            end else begin
               recs[0] = mk_rec(K_BADOP, C_OP, 8'd0);
               n       = NREC_W'(1);
            end
            nxt.mode = MODE_IDLE;
            nxt.pend = 8'd0;
         end else begin
            recs[0]  = close0;
            recs[1]  = close1;
            n        = close_n;
            nxt.mode = MODE_OP;
            nxt.pend = ch;
         end
      end else if (ch == CH_DOLLAR) begin
         // comment leaves the open token alone
         nxt.in_comment = 1'b1;
      end else begin
         if (cur.mode != MODE_WORD && cur.mode != MODE_INT) begin
            recs[0]  = close0;
            recs[1]  = close1;
            n        = close_n;
            nxt.pend = 8'd0;
            if (ch >= CH_0 && ch <= CH_9) begin
               nxt.mode = MODE_INT;
            end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
               nxt.mode     = MODE_STR;
               nxt.quote_dq = (ch == CH_DQUOTE);
            end else begin
               nxt.mode = MODE_WORD;
            end
         end
         // the opening quote itself gives no word
         if (nxt.mode == MODE_WORD) begin
            recs[n[1:0]] = mk_rec(K_CHAR, C_WORD,
                                  (ch >= CH_UA && ch <= CH_UZ) ? ch + CASE_OFS : ch);
            n            = n + NREC_W'(1);
         end else if (nxt.mode == MODE_INT) begin
            recs[n[1:0]] = mk_rec(K_CHAR, C_INT, ch);
            n            = n + NREC_W'(1);
         end
      end
      if (n != '0) begin
         recs[n[1:0] - 2'd1].last = 1'b1;
      end
      rec_cnt = n;
   end

endmodule

/* sim/tb_sql_style_lexer.sv */
// testbench for sql_style_lexer: directed table then random token streams under idling phases
// depends on sqllex_pkg and lexer rtl; records checked against table rows or a tokenizer model
`timescale 1ns / 1ps

module tb_sql_style_lexer;
   import sqllex_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int USE_PREDICTOR = -1;
   localparam int PHASE_WORDS   = 64;
   localparam int DRAIN_CYCLES  = 20;
   localparam rec_type NO_REC   = '0;
   localparam logic [7:0] SEP_SET [0:6] = '{CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE,
                                            CH_DOT, CH_COMMA, CH_SEMI};
   localparam logic [7:0] OP_SET [0:7]  = '{CH_EQ, CH_BANG, CH_PLUS, CH_MINUS,
                                            CH_STAR, CH_SLASH, CH_LT, CH_GT};

   typedef struct packed {
      logic [7:0] ch;
      logic       le;
      int         n_typed;
      rec_type    r0;
      rec_type    r1;
      rec_type    r2;
   } dir_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_ch;
   logic       req_line_end;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_token_class;
   logic [7:0] rsp_char_out;
   logic       rsp_last;

   // tokenizer model state
   mode_type   lx_mode;
   logic       lx_comment;
   logic       lx_dq;
   logic [7:0] lx_pend;

   rec_type    step_recs[$];
   rec_type    token_recs_due[$];
   dir_row_type dir_tab[$];

   int idle_pct;
   int stall_pct;
   int errors;
   int cycle_count;
   int words_in;
   int live_words;
   int recs_out;
   int kind_seen[4];

   sql_style_lexer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_line_end    (req_line_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_token_class (rsp_token_class),
      .rsp_char_out    (rsp_char_out),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rec_type rec(logic [1:0] k, logic [2:0] cls, logic [7:0] c);
      rec_type r;
      r.kind        = k;
      r.token_class = cls;
      r.char_out    = c;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic dir_row_type drow(logic [7:0] ch, logic le, int n,
                                        rec_type r0, rec_type r1, rec_type r2);
      dir_row_type w;
      w.ch      = ch;
      w.le      = le;
      w.n_typed = n;
      w.r0      = r0;
      w.r1      = r1;
      w.r2      = r2;
      return w;
   endfunction

   function automatic void add_row(dir_row_type w);
      dir_tab.insert(dir_tab.size(), w);
   endfunction

   function automatic void queue_due(rec_type r);
      token_recs_due.insert(token_recs_due.size(), r);
   endfunction

   function automatic void put_rec(logic [1:0] k, logic [2:0] cls, logic [7:0] c);
      step_recs.insert(step_recs.size(), rec(k, cls, c));
   endfunction

   function automatic void close_token();
      case (lx_mode)
         MODE_WORD: put_rec(K_END, C_WORD, 8'd0);
         MODE_OP: begin
            put_rec(K_CHAR, C_OP, lx_pend);
            put_rec(K_END, C_OP, 8'd0);
         end
         MODE_INT: put_rec(K_END, C_INT, 8'd0);
         default: ;
      endcase
      if (lx_mode != MODE_STR) lx_mode = MODE_IDLE;
      lx_pend = 8'd0;
   endfunction

   // one lexer step: leaves the records this word causes in step_recs
   function automatic void tokenize_char(logic [7:0] c, logic le);
      logic [7:0] q;
      rec_type    r;
      step_recs.delete();
      if (le) begin
         if (lx_mode == MODE_STR) put_rec(K_DISC, C_STR, 8'd0);
         else close_token();
         lx_mode    = MODE_IDLE;
         lx_comment = 1'b0;
         lx_dq      = 1'b0;
         lx_pend    = 8'd0;
      end else if (lx_comment) begin
         if (c == CH_LF || c == CH_CR) lx_comment = 1'b0;
      end else if (lx_mode == MODE_STR) begin
         q = lx_dq ? CH_DQUOTE : CH_SQUOTE;
         if (c == q) begin
            put_rec(K_END, C_STR, 8'd0);
            lx_mode = MODE_IDLE;
            lx_dq   = 1'b0;
         end else begin
            put_rec(K_CHAR, C_STR, c);
         end
      end else begin
         case (c)
            CH_SP, CH_LF, CH_CR: close_token();
            CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE, CH_DOT, CH_COMMA, CH_SEMI: begin
               close_token();
               put_rec(K_CHAR, C_SEP, c);
               put_rec(K_END, C_SEP, 8'd0);
            end
            CH_EQ, CH_BANG, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LT, CH_GT: begin
               if (lx_mode == MODE_OP) begin
                  if ((lx_pend == CH_EQ && c == CH_EQ) || (lx_pend == CH_BANG && c == CH_EQ) ||
                      (lx_pend == CH_SLASH && c == CH_SLASH) ||
                      (lx_pend == CH_LT && c == CH_EQ) || (lx_pend == CH_GT && c == CH_EQ) ||
                      (lx_pend == CH_LT && c == CH_GT)) begin
                     put_rec(K_CHAR, C_OP, lx_pend);
                     put_rec(K_CHAR, C_OP, c);
                     put_rec(K_END, C_OP, 8'd0);
                  end else begin
                     put_rec(K_BADOP, C_OP, 8'd0);
                  end
                  lx_mode = MODE_IDLE;
                  lx_pend = 8'd0;
               end else begin
                  close_token();
                  lx_mode = MODE_OP;
                  lx_pend = c;
               end
            end
            CH_DOLLAR: lx_comment = 1'b1;
            default: begin
               if (lx_mode != MODE_WORD && lx_mode != MODE_INT) begin
                  close_token();
                  if (c >= CH_0 && c <= CH_9) begin
                     lx_mode = MODE_INT;
                  end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                     lx_mode = MODE_STR;
                     lx_dq   = (c == CH_DQUOTE);
                  end else begin
                     lx_mode = MODE_WORD;
                  end
               end
               if (lx_mode == MODE_WORD)
                  put_rec(K_CHAR, C_WORD, (c >= CH_UA && c <= CH_UZ) ? c + CASE_OFS : c);
               else if (lx_mode == MODE_INT)
                  put_rec(K_CHAR, C_INT, c);
            end
         endcase
      end
      if (step_recs.size() > 0) begin
         r = step_recs[step_recs.size()-1];
         r.last = 1'b1;
         step_recs[step_recs.size()-1] = r;
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch at record %0d: %s got %0h want %0h", recs_out, what, got, want);
   endtask

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(dir_row_type w);
      rec_type r;
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_ch       = w.ch;
      req_line_end = w.le;
      do @(posedge clock); while (!req_ready);
      words_in++;
      if (!lx_comment || w.le) live_words++;
      tokenize_char(w.ch, w.le);
      if (w.n_typed == USE_PREDICTOR) begin
         foreach (step_recs[k]) queue_due(step_recs[k]);
      end else begin
         for (int k = 0; k < w.n_typed; k++) begin
            r = (k == 0) ? w.r0 : (k == 1) ? w.r1 : w.r2;
            r.last = (k == w.n_typed - 1);
            queue_due(r);
         end
      end
      @(negedge clock);
   endtask

   task automatic send_pred(logic [7:0] c, logic le);
      send_word(drow(c, le, USE_PREDICTOR, NO_REC, NO_REC, NO_REC));
   endtask

   // any byte that is not whitespace, separator, operator, comment, quote or digit
   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      logic       ok;
      do begin
         c  = 8'($urandom_range(255));
         ok = 1'b1;
         case (c)
            CH_SP, CH_LF, CH_CR, CH_DOLLAR, CH_SQUOTE, CH_DQUOTE,
            CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE, CH_DOT, CH_COMMA, CH_SEMI,
            CH_EQ, CH_BANG, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LT, CH_GT: ok = 1'b0;
            default: if (c >= CH_0 && c <= CH_9) ok = 1'b0;
         endcase
      end while (!ok);
      return c;
   endfunction

   function automatic logic [7:0] pick_letter();
      logic [7:0] base;
      base = $urandom_range(1) ? CH_UA : CH_UA + CASE_OFS;
      return base + 8'($urandom_range(25));
   endfunction

   task automatic emit_delim();
      case ($urandom_range(9))
         0, 1, 2: send_pred(CH_SP, 1'b0);
         3:       send_pred(CH_LF, 1'b0);
         4:       send_pred(CH_CR, 1'b0);
         5, 6:    send_pred(SEP_SET[$urandom_range(6)], 1'b0);
         7:       send_pred(OP_SET[$urandom_range(7)], 1'b0);
         default: send_pred(8'($urandom_range(255)), 1'b1);
      endcase
   endtask

   task automatic emit_sequence();
      int pick;
      int len;
      logic [7:0] q;
      logic [7:0] c;
      pick = $urandom_range(99);
      if (pick < 20) begin
         // word with mixed case, digits and the odd quote or high byte inside
         send_pred($urandom_range(3) == 0 ? pick_plain() : pick_letter(), 1'b0);
         len = $urandom_range(7);
         for (int k = 0; k < len; k++) begin
            case ($urandom_range(9))
               0:       send_pred(CH_0 + 8'($urandom_range(9)), 1'b0);
               1:       send_pred($urandom_range(1) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
               2:       send_pred(pick_plain(), 1'b0);
               default: send_pred(pick_letter(), 1'b0);
            endcase
         end
         emit_delim();
      end else if (pick < 32) begin
         len = $urandom_range(1, 6);
         for (int k = 0; k < len; k++) send_pred(CH_0 + 8'($urandom_range(9)), 1'b0);
         if ($urandom_range(4) == 0) send_pred(pick_letter(), 1'b0);
         emit_delim();
      end else if (pick < 45) begin
         q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
         send_pred(q, 1'b0);
         len = $urandom_range(8);
         for (int k = 0; k < len; k++) begin
            do c = 8'($urandom_range(255)); while (c == q);
            send_pred(c, 1'b0);
         end
         if ($urandom_range(6) == 0) send_pred(8'($urandom_range(255)), 1'b1);
         else send_pred(q, 1'b0);
      end else if (pick < 60) begin
         c = OP_SET[$urandom_range(7)];
         send_pred(c, 1'b0);
         case ($urandom_range(3))
            0, 1: begin
               case (c)
                  CH_EQ, CH_BANG, CH_GT: send_pred(CH_EQ, 1'b0);
                  CH_SLASH:              send_pred(CH_SLASH, 1'b0);
                  CH_LT:                 send_pred($urandom_range(1) ? CH_EQ : CH_GT, 1'b0);
                  default:               send_pred(OP_SET[$urandom_range(7)], 1'b0);
               endcase
            end
            2:       send_pred(OP_SET[$urandom_range(7)], 1'b0);
            default: if ($urandom_range(1)) emit_delim(); else send_pred(pick_letter(), 1'b0);
         endcase
      end else if (pick < 68) begin
         send_pred(SEP_SET[$urandom_range(6)], 1'b0);
      end else if (pick < 76) begin
         // comment, sometimes in the middle of an open token
         if ($urandom_range(1)) send_pred(pick_letter(), 1'b0);
         send_pred(CH_DOLLAR, 1'b0);
         len = $urandom_range(6);
         for (int k = 0; k < len; k++) begin
            do c = 8'($urandom_range(255)); while (c == CH_LF || c == CH_CR);
            send_pred(c, 1'b0);
         end
         case ($urandom_range(2))
            0:       send_pred(CH_LF, 1'b0);
            1:       send_pred(CH_CR, 1'b0);
            default: send_pred(8'($urandom_range(255)), 1'b1);
         endcase
         if ($urandom_range(1)) send_pred(pick_letter(), 1'b0);
      end else if (pick < 84) begin
         emit_delim();
      end else begin
         len = $urandom_range(1, 4);
         for (int k = 0; k < len; k++)
            send_pred(8'($urandom_range(255)), ($urandom_range(9) == 0));
      end
   endtask

   // result side: random stalls at the falling edge
   always @(negedge clock) begin
      if (!reset) rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rec_type due;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped at cycle limit with %0d records outstanding",
                  token_recs_due.size());
         $display("FAILURE");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         recs_out++;
         kind_seen[rsp_kind]++;
         if (token_recs_due.size() == 0) begin
            report_mismatch("record with nothing due, kind", rsp_kind, 0);
         end else begin
            due = token_recs_due.pop_front();
            if (rsp_kind != due.kind) report_mismatch("kind", rsp_kind, due.kind);
            if (rsp_token_class != due.token_class)
               report_mismatch("token_class", rsp_token_class, due.token_class);
            if (rsp_char_out != due.char_out)
               report_mismatch("char_out", rsp_char_out, due.char_out);
            if (rsp_last != due.last) report_mismatch("last", rsp_last, due.last);
         end
      end
   end

   initial begin
      int phase_start;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_ch       = 8'd0;
      req_line_end = 1'b0;
      rsp_ready    = 1'b0;
      idle_pct     = 0;
      stall_pct    = 0;
      errors       = 0;
      cycle_count  = 0;
      words_in     = 0;
      live_words   = 0;
      recs_out     = 0;
      kind_seen    = '{0, 0, 0, 0};
      lx_mode      = MODE_IDLE;
      lx_comment   = 1'b0;
      lx_dq        = 1'b0;
      lx_pend      = 8'd0;

      add_row(drow(8'h00, 1'b1, 0, NO_REC, NO_REC, NO_REC));
      add_row(drow("A", 1'b0, 1, rec(K_CHAR, C_WORD, "a"), NO_REC, NO_REC));
      add_row(drow("Z", 1'b0, 1, rec(K_CHAR, C_WORD, "z"), NO_REC, NO_REC));
      add_row(drow(8'hFF, 1'b0, 1, rec(K_CHAR, C_WORD, 8'hFF), NO_REC, NO_REC));
      add_row(drow(8'h00, 1'b0, 1, rec(K_CHAR, C_WORD, 8'h00), NO_REC, NO_REC));
      // tab is an ordinary character
      add_row(drow(8'h09, 1'b0, 1, rec(K_CHAR, C_WORD, 8'h09), NO_REC, NO_REC));
      add_row(drow(CH_SP, 1'b0, 1, rec(K_END, C_WORD, 8'd0), NO_REC, NO_REC));
      add_row(drow(CH_9, 1'b0, 1, rec(K_CHAR, C_INT, CH_9), NO_REC, NO_REC));
      add_row(drow(CH_LPAR, 1'b0, 3, rec(K_END, C_INT, 8'd0),
                   rec(K_CHAR, C_SEP, CH_LPAR), rec(K_END, C_SEP, 8'd0)));
      add_row(drow(CH_LT, 1'b0, 0, NO_REC, NO_REC, NO_REC));
      add_row(drow(CH_GT, 1'b0, 3, rec(K_CHAR, C_OP, CH_LT),
                   rec(K_CHAR, C_OP, CH_GT), rec(K_END, C_OP, 8'd0)));
      add_row(drow(CH_BANG, 1'b0, 0, NO_REC, NO_REC, NO_REC));
      add_row(drow(CH_PLUS, 1'b0, 1, rec(K_BADOP, C_OP, 8'd0), NO_REC, NO_REC));
      add_row(drow("k", 1'b0, USE_PREDICTOR, NO_REC, NO_REC, NO_REC));
      // comment inside an open word, closed by return
      add_row(drow(CH_DOLLAR, 1'b0, 0, NO_REC, NO_REC, NO_REC));
      add_row(drow("x", 1'b0, 0, NO_REC, NO_REC, NO_REC));
      add_row(drow(CH_CR, 1'b0, 0, NO_REC, NO_REC, NO_REC));
      add_row(drow("5", 1'b0, USE_PREDICTOR, NO_REC, NO_REC, NO_REC));
      add_row(drow(CH_LF, 1'b0, 1, rec(K_END, C_WORD, 8'd0), NO_REC, NO_REC));
      add_row(drow(CH_DQUOTE, 1'b0, 0, NO_REC, NO_REC, NO_REC));
      add_row(drow(CH_SQUOTE, 1'b0, 1, rec(K_CHAR, C_STR, CH_SQUOTE),
                   NO_REC, NO_REC));
      add_row(drow(8'h80, 1'b0, USE_PREDICTOR, NO_REC, NO_REC, NO_REC));
      add_row(drow(CH_DQUOTE, 1'b0, 1, rec(K_END, C_STR, 8'd0), NO_REC, NO_REC));
      add_row(drow(CH_SQUOTE, 1'b0, USE_PREDICTOR, NO_REC, NO_REC, NO_REC));
      add_row(drow("Q", 1'b0, USE_PREDICTOR, NO_REC, NO_REC, NO_REC));
      // unterminated string dropped at line end, ch ignored
      add_row(drow(8'hA5, 1'b1, 1, rec(K_DISC, C_STR, 8'd0), NO_REC, NO_REC));
      add_row(drow(CH_EQ, 1'b0, USE_PREDICTOR, NO_REC, NO_REC, NO_REC));
      add_row(drow(8'h5A, 1'b1, 2, rec(K_CHAR, C_OP, CH_EQ),
                   rec(K_END, C_OP, 8'd0), NO_REC));

      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) send_word(dir_tab[i]);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 87; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 87; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         phase_start = live_words;
         while (live_words - phase_start < PHASE_WORDS) emit_sequence();
      end
      req_valid = 1'b0;

      while (token_recs_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d input words through four idling phases, %0d result words checked",
               words_in, recs_out);
      $display("records seen: %0d chars, %0d token ends, %0d dropped strings, %0d bad ops",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/sqllex_pkg.sv
rtl/core/sqllex_decode.sv
rtl/core/sql_style_lexer.sv
sim/tb_sql_style_lexer.sv
